// File: design/tkbc_pkg.sv
// shared types and constants of the table keystream byte cipher
package tkbc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ENCRYPT = 2'd1,
    ACT_DECRYPT = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A_FIRST  = 3'd0,
    CFG_COEF_B_FIRST  = 3'd1,
    CFG_COEF_C_FIRST  = 3'd2,
    CFG_SEED_FIRST    = 3'd3,
    CFG_COEF_A_SECOND = 3'd4,
    CFG_COEF_B_SECOND = 3'd5,
    CFG_COEF_C_SECOND = 3'd6,
    CFG_SEED_SECOND   = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_FIN,
    BK_SQ,
    BK_STEP,
    BK_XRD,
    BK_XWR,
    BK_ACK
  } back_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_message;
    logic              last_of_message;
    logic              keep_advance;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              is_data;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] coef_a_first;
    logic [BYTE_W-1:0] coef_b_first;
    logic [BYTE_W-1:0] coef_c_first;
    logic [BYTE_W-1:0] seed_first;
    logic [BYTE_W-1:0] coef_a_second;
    logic [BYTE_W-1:0] coef_b_second;
    logic [BYTE_W-1:0] coef_c_second;
    logic [BYTE_W-1:0] seed_second;
  } cfg_t;

  typedef struct packed {
    action_t           kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] p1;
    logic [BYTE_W-1:0] p2;
  } cmd_t;

endpackage

// File: design/tkbc_fifo.sv
// small first-in first-out queue of packed words
module tkbc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: design/tkbc_front.sv
// front end: classifies requests and steps the message positions
module tkbc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tkbc_pkg::in_item_t item,
  output tkbc_pkg::cmd_t    cmd
);
  import tkbc_pkg::*;

  logic [BYTE_W-1:0] inner;
  logic [BYTE_W-1:0] outer;
  logic [BYTE_W-1:0] saved_inner;
  logic [BYTE_W-1:0] saved_outer;
  logic [BYTE_W-1:0] base_inner;
  logic [BYTE_W-1:0] base_outer;
  action_t           kind;

  assign kind       = action_t'(item.action);
  assign base_inner = item.first_of_message ? inner : saved_inner;
  assign base_outer = item.first_of_message ? outer : saved_outer;

  always_comb begin
    cmd.kind      = kind;
    cmd.data_byte = item.data_byte;
    cmd.p1        = inner;
    cmd.p2        = outer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner       <= '0;
      outer       <= '0;
      saved_inner <= '0;
      saved_outer <= '0;
    end else if (accept) begin
      case (kind)
        ACT_INIT: begin
          inner       <= '0;
          outer       <= '0;
          saved_inner <= '0;
          saved_outer <= '0;
        end
        ACT_ENCRYPT, ACT_DECRYPT: begin
          saved_inner <= base_inner;
          saved_outer <= base_outer;
          if (item.last_of_message && !item.keep_advance) begin
            inner <= base_inner;
            outer <= base_outer;
          end else begin
            inner <= inner + 1'b1;
            if (inner == '1) begin
              outer <= outer + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/tkbc_back.sv
// back end: key tables, table build sequencer and byte transform
module tkbc_back (
  input  logic              clk,
  input  logic              rst,
  input  tkbc_pkg::cfg_t    cfg,
  input  logic              cmd_empty,
  input  tkbc_pkg::cmd_t    cmd_in,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output tkbc_pkg::result_t res
);
  import tkbc_pkg::*;

  localparam logic [3:0]  XOR_LAST   = 4'd9;
  localparam logic [7:0]  MUL_BASE   = 8'h3f;
  localparam logic [7:0]  MUL_COND   = 8'h2f;
  localparam logic [7:0]  MUL_POS    = 8'h28;
  localparam logic [7:0]  ADD_TT     = 8'hee;
  localparam logic [7:0]  ADD_PP     = 8'h4a;
  localparam logic [7:0]  ADD_P33    = 8'd33;
  localparam logic [7:0]  ADD_P31    = 8'd31;
  localparam logic [7:0]  ADD_ROT    = 8'd6;
  localparam logic [7:0]  MASK_OUTER = 8'h31;
  localparam logic [7:0]  MASK_LOW   = 8'h03;
  localparam logic [7:0]  MASK_ZERO  = 8'h13;
  localparam logic [15:0] PROD_DIV   = 16'h23df;

  function automatic logic [3:0] mod9(input logic [7:0] x);
    logic [6:0] s;
    logic [4:0] v;
    s = 7'(x[7:6]) + 7'(x[5:0]);
    v = 5'(s[2:0]) + 5'd9 - 5'(s[6:3]);
    if (v >= 5'd9) begin
      v = v - 5'd9;
    end
    return v[3:0];
  endfunction

  back_state_t state;
  back_state_t state_next;

  logic [BYTE_W-1:0] tbl1 [256];
  logic [BYTE_W-1:0] tbl2 [256];
  logic [BYTE_W-1:0] rd1;
  logic [BYTE_W-1:0] rd2;
  logic [BYTE_W-1:0] ra1;
  logic [BYTE_W-1:0] ra2;
  logic              we1;
  logic              we2;
  logic [BYTE_W-1:0] wa1;
  logic [BYTE_W-1:0] wd1;

  cmd_t              cmd_r;
  logic [BYTE_W-1:0] cnt;
  logic [3:0]        xi;
  logic [BYTE_W-1:0] x1;
  logic [BYTE_W-1:0] x2;
  logic [BYTE_W-1:0] sq1;
  logic [BYTE_W-1:0] sq2;
  logic [15:0]       x1_sq;
  logic [15:0]       x2_sq;
  logic [15:0]       x1_step;
  logic [15:0]       x2_step;

  logic [BYTE_W-1:0] t1;
  logic [BYTE_W-1:0] t2;
  logic [15:0]       prod;
  logic [6:0]        rprod;
  logic [BYTE_W-1:0] t1_base;
  logic [BYTE_W-1:0] t1_cond;
  logic [BYTE_W-1:0] p1_pos;
  logic [15:0]       prod_full;
  logic [7:0]        rprod_full;
  logic [15:0]       t1_base_full;
  logic [15:0]       t1_cond_full;
  logic [15:0]       p1_pos_full;

  logic [2:0]        quo;
  logic [BYTE_W-1:0] sum_tt;
  logic [BYTE_W-1:0] prod2;
  logic [BYTE_W-1:0] key;
  logic [BYTE_W-1:0] enc_in;
  logic [15:0]       rot_l;
  logic [15:0]       rot_r;
  logic [BYTE_W-1:0] rot_sum;
  logic [2:0]        amt;
  logic [BYTE_W-1:0] res_byte;

  // table build recurrence
  assign x1_sq   = 16'(x1) * 16'(x1);
  assign x2_sq   = 16'(x2) * 16'(x2);
  assign x1_step = 16'(cfg.coef_a_first) * 16'(sq1) + 16'(cfg.coef_b_first) * 16'(x1)
                   + 16'(cfg.coef_c_first);
  assign x2_step = 16'(cfg.coef_a_second) * 16'(sq2) + 16'(cfg.coef_b_second) * 16'(x2)
                   + 16'(cfg.coef_c_second);

  assign ra1 = (state == BK_XRD) ? {2'b00, xi, 2'b01} : cmd_r.p1;
  assign ra2 = (state == BK_XRD) ? {2'b00, xi, 2'b11} : cmd_r.p2;

  always_ff @(posedge clk) begin
    if (we1) begin
      tbl1[wa1] <= wd1;
    end
    if (we2) begin
      tbl2[cnt] <= x2;
    end
    rd1 <= tbl1[ra1];
    rd2 <= tbl2[ra2];
  end

  // multiply stage
  assign prod_full    = 16'(rd1) * 16'(rd2);
  assign rprod_full   = 8'(mod9(cmd_r.p1)) * 8'(mod9(rd2));
  assign t1_base_full = 16'(rd1) * 16'(MUL_BASE);
  assign t1_cond_full = 16'(rd1) * 16'(MUL_COND);
  assign p1_pos_full  = 16'(cmd_r.p1) * 16'(MUL_POS);

  // finish stage
  always_comb begin
    quo = '0;
    for (int k = 1; k < 8; k++) begin
      if (prod >= 16'(k * PROD_DIV)) begin
        quo = 3'(k);
      end
    end
  end

  assign sum_tt = t1 + t2 + ADD_TT;
  assign prod2  = {prod[6:0], 1'b0};

  always_comb begin
    key = t1 ^ t1_base ^ t2 ^ prod[7:0] ^ 8'(quo) ^ sum_tt ^ cmd_r.p1 ^ cmd_r.p2;
    if ((cmd_r.p2 & MASK_OUTER) != '0) begin
      key = key ^ t1_base ^ p1_pos ^ prod[7:0] ^ sum_tt ^ cmd_r.p1 ^ cmd_r.p2;
    end
    if ((cmd_r.p1 & MASK_LOW) != '0) begin
      key = key ^ t1_cond ^ (cmd_r.p1 + cmd_r.p2 + ADD_PP) ^ prod2 ^ sum_tt ^ cmd_r.p2;
    end
    if ((cmd_r.p1 & MASK_ZERO) == '0) begin
      key = key ^ t1_cond ^ (cmd_r.p1 + ADD_P33) ^ prod2 ^ sum_tt ^ cmd_r.p2;
    end
    if (mod9({1'b0, rprod}) == 4'd1) begin
      key = key ^ t1_cond ^ (cmd_r.p1 + ADD_P31) ^ prod2 ^ sum_tt ^ cmd_r.p2;
    end
  end

  assign rot_sum = t1 + t2 + ADD_ROT;
  assign amt     = rot_sum[2:0];
  assign enc_in  = cmd_r.data_byte ^ key;
  assign rot_l   = {enc_in, enc_in} << amt;
  assign rot_r   = {cmd_r.data_byte, cmd_r.data_byte} >> amt;
  assign res_byte = (cmd_r.kind == ACT_ENCRYPT) ? rot_l[15:8] : (rot_r[7:0] ^ key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    we1        = 1'b0;
    we2        = 1'b0;
    wa1        = cnt;
    wd1        = x1;
    res        = '0;
    case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd_in.kind)
            ACT_INIT:                 state_next = BK_SQ;
            ACT_ENCRYPT, ACT_DECRYPT: state_next = BK_READ;
            default:                  state_next = BK_ACK;
          endcase
        end
      end
      BK_READ: state_next = BK_MUL;
      BK_MUL:  state_next = BK_FIN;
      BK_FIN: begin
        res.result_byte = res_byte;
        res.is_data     = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_SQ: state_next = BK_STEP;
      BK_STEP: begin
        we1 = 1'b1;
        we2 = 1'b1;
        state_next = (cnt == '1) ? BK_XRD : BK_SQ;
      end
      BK_XRD: state_next = BK_XWR;
      BK_XWR: begin
        we1 = 1'b1;
        wa1 = {2'b00, xi, 2'b01};
        wd1 = rd1 ^ rd2;
        state_next = (xi == XOR_LAST) ? BK_ACK : BK_XRD;
      end
      BK_ACK: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_pop) begin
      cmd_r <= cmd_in;
      x1    <= cfg.seed_first;
      x2    <= cfg.seed_second;
      cnt   <= '0;
      xi    <= '0;
    end
    if (state == BK_SQ) begin
      sq1 <= x1_sq[7:0];
      sq2 <= x2_sq[7:0];
    end
    if (state == BK_STEP) begin
      x1  <= x1_step[7:0];
      x2  <= x2_step[7:0];
      cnt <= cnt + 1'b1;
    end
    if (state == BK_XWR) begin
      xi <= xi + 1'b1;
    end
    if (state == BK_MUL) begin
      t1      <= rd1;
      t2      <= rd2;
      prod    <= prod_full;
      rprod   <= rprod_full[6:0];
      t1_base <= t1_base_full[7:0];
      t1_cond <= t1_cond_full[7:0];
      p1_pos  <= p1_pos_full[7:0];
    end
  end

endmodule

// File: design/table_keystream_byte_cipher.sv
// top level of the table keystream byte cipher
//
//   channel   handshake          payload
//   request   push / full        item   (in_item_t)
//   result    empty / pop        result (result_t)
//   config    cfg_we             cfg_index, cfg_data
//
// a data byte passes through the back end sequencer steps pop, table read,
// multiply and finish; an init pops, builds all 256 table entries (square,
// then step for each entry), runs the xor pass over 10 entries and acks.
// rst clears positions, queues and config; the key tables keep their contents.
// full rises when the command queue fills; the back end holds a finished
// result while the result queue is full.
module table_keystream_byte_cipher #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  tkbc_pkg::in_item_t           item,
  output logic                         empty,
  input  logic                         pop,
  output tkbc_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic [tkbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkbc_pkg::BYTE_W-1:0]  cfg_data
);
  import tkbc_pkg::*;

  cfg_t                 cfg;
  cmd_t                 cmd_wr;
  cmd_t                 cmd_rd;
  logic [$bits(cmd_t)-1:0]    cmd_rdata;
  logic [$bits(result_t)-1:0] res_rdata;
  logic                 accept;
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic                 res_full;
  logic                 res_push;
  result_t              res_wr;

  assign accept = push && !full;
  assign cmd_rd = cmd_t'(cmd_rdata);
  assign result = result_t'(res_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_COEF_A_FIRST:  cfg.coef_a_first  <= cfg_data;
        CFG_COEF_B_FIRST:  cfg.coef_b_first  <= cfg_data;
        CFG_COEF_C_FIRST:  cfg.coef_c_first  <= cfg_data;
        CFG_SEED_FIRST:    cfg.seed_first    <= cfg_data;
        CFG_COEF_A_SECOND: cfg.coef_a_second <= cfg_data;
        CFG_COEF_B_SECOND: cfg.coef_b_second <= cfg_data;
        CFG_COEF_C_SECOND: cfg.coef_c_second <= cfg_data;
        CFG_SEED_SECOND:   cfg.seed_second   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tkbc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cmd    (cmd_wr)
  );

  tkbc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (cmd_wr),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  tkbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_in    (cmd_rd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr)
  );

  tkbc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wr),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule

// File: verif/tb.sv
// self-checking testbench for the table keystream byte cipher, predicting every result in place
module tb;
  import tkbc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_PER_PHASE = 482;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  table_keystream_byte_cipher uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_item_t cipher_requests[$];
  result_t expected_results[$];

  cfg_t model_cfg = '0;
  logic [7:0] key_first [256];
  logic [7:0] key_second [256];
  logic [7:0] pos_in = '0, pos_out = '0, save_in = '0, save_out = '0;

  int errs = 0;
  int results_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit taken = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] recur(int unsigned a, int unsigned b, int unsigned c,
                                       int unsigned x);
    return 8'((a * x * x + b * x + c) & 32'hff);
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int unsigned n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic logic [7:0] rotr8(logic [7:0] v, int unsigned n);
    logic [15:0] w;
    w = {v, v} >> n;
    return w[7:0];
  endfunction

  function automatic logic [7:0] keystream_byte(int unsigned p1, int unsigned p2,
                                                int unsigned t1, int unsigned t2);
    int unsigned k, prod;
    prod = t1 * t2;
    k = t1 ^ (t1 * 32'h33f) ^ t2 ^ prod ^ (prod / 32'h23df) ^ (t1 + t2 + 32'h34fee) ^ p1 ^ p2;
    if ((p2 & 32'h31) != 0)
      k ^= (t1 * 32'h3423f) ^ (p1 * 2344) ^ prod ^ (t1 + t2 + 32'h343fee) ^ p1 ^ p2;
    if ((p1 & 32'h3) != 0)
      k ^= (t1 * 32'h3422f) ^ (p1 + p2 + 32'h234a) ^ (prod * 2) ^ (t1 + t2 + 32'h343fee) ^ p2;
    if ((p1 & 32'h13) == 0)
      k ^= (t1 * 32'h3422f) ^ (p1 + 33) ^ (prod * 2) ^ (t1 + t2 + 32'h343fee) ^ p2;
    if ((p1 * t2) % 9 == 1)
      k ^= (t1 * 32'h342f) ^ (p1 + 31) ^ (prod * 2) ^ (t1 + t2 + 32'h343fee) ^ p2;
    return k[7:0];
  endfunction

  function automatic result_t cipher_predict(in_item_t it);
    result_t r;
    int unsigned t1, t2, amt;
    logic [7:0] kb, xf, xs;
    r = '0;
    case (action_t'(it.action))
      ACT_INIT: begin
        xf = model_cfg.seed_first;
        xs = model_cfg.seed_second;
        for (int k = 0; k < 256; k++) begin
          key_first[k] = xf;
          key_second[k] = xs;
          xf = recur(model_cfg.coef_a_first, model_cfg.coef_b_first, model_cfg.coef_c_first, xf);
          xs = recur(model_cfg.coef_a_second, model_cfg.coef_b_second,
                     model_cfg.coef_c_second, xs);
        end
        for (int k = 0; k < 10; k++) key_first[4 * k + 1] ^= key_second[4 * k + 3];
        pos_in = '0;
        pos_out = '0;
        save_in = '0;
        save_out = '0;
      end
      ACT_ENCRYPT, ACT_DECRYPT: begin
        if (it.first_of_message) begin
          save_in = pos_in;
          save_out = pos_out;
        end
        t1 = key_first[pos_in];
        t2 = key_second[pos_out];
        kb = keystream_byte(pos_in, pos_out, t1, t2);
        amt = (t1 + t2 + 6) & 7;
        if (action_t'(it.action) == ACT_ENCRYPT) r.result_byte = rotl8(it.data_byte ^ kb, amt);
        else r.result_byte = rotr8(it.data_byte, amt) ^ kb;
        r.is_data = 1'b1;
        pos_in = pos_in + 8'd1;
        if (pos_in == 8'd0) pos_out = pos_out + 8'd1;
        if (it.last_of_message && !it.keep_advance) begin
          pos_in = save_in;
          pos_out = save_out;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t cipher_request(action_t a, logic [7:0] d, logic f, logic l,
                                              logic k);
    in_item_t it;
    it.action = a;
    it.data_byte = d;
    it.first_of_message = f;
    it.last_of_message = l;
    it.keep_advance = k;
    return it;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || taken) begin
      taken = 1'b0;
      if (cipher_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
        item <= cipher_requests.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && push && !full) begin
      expected_results.push_back(cipher_predict(item));
      taken = 1'b1;
    end
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result %02h/%0b with nothing expected", result.result_byte, result.is_data);
        errs++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.result_byte !== exp_r.result_byte) begin
          $error("result_byte expected %02h got %02h", exp_r.result_byte, result.result_byte);
          errs++;
        end
        if (result.is_data !== exp_r.is_data) begin
          $error("is_data expected %0b got %0b", exp_r.is_data, result.is_data);
          errs++;
        end
      end
      results_seen++;
      if (results_seen % 400 == 200) hold_req = 1'b1;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[table_keystream_byte_cipher] ERROR");
    $finish;
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (cipher_requests.size() != 0 || (push && !taken) || expected_results.size() != 0);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic set_config(cfg_t c);
    write_reg(CFG_COEF_A_FIRST, c.coef_a_first);
    write_reg(CFG_COEF_B_FIRST, c.coef_b_first);
    write_reg(CFG_COEF_C_FIRST, c.coef_c_first);
    write_reg(CFG_SEED_FIRST, c.seed_first);
    write_reg(CFG_COEF_A_SECOND, c.coef_a_second);
    write_reg(CFG_COEF_B_SECOND, c.coef_b_second);
    write_reg(CFG_COEF_C_SECOND, c.coef_c_second);
    write_reg(CFG_SEED_SECOND, c.seed_second);
    @(negedge clk);
    cfg_we <= 1'b0;
    model_cfg = c;
  endtask

  task automatic add_directed();
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'h00, 1'b1, 1'b0, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'hff, 1'b0, 1'b0, 1'b1));
    cipher_requests.push_back(cipher_request(ACT_DECRYPT, 8'h00, 1'b0, 1'b0, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_DECRYPT, 8'hff, 1'b0, 1'b1, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'ha5, 1'b1, 1'b1, 1'b1));
    // last byte with no first byte restores the older save
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'h5a, 1'b0, 1'b1, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_UNUSED, 8'hff, 1'b1, 1'b1, 1'b1));
    cipher_requests.push_back(cipher_request(ACT_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_DECRYPT, 8'h3c, 1'b1, 1'b0, 1'b1));
    cipher_requests.push_back(cipher_request(ACT_DECRYPT, 8'hc3, 1'b0, 1'b1, 1'b1));
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'h7e, 1'b1, 1'b0, 1'b0));
    // init in the middle of a message clears the saved positions
    cipher_requests.push_back(cipher_request(ACT_INIT, 8'h00, 1'b0, 1'b0, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'h81, 1'b0, 1'b1, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_DECRYPT, 8'h18, 1'b1, 1'b1, 1'b0));
    cipher_requests.push_back(cipher_request(ACT_ENCRYPT, 8'h01, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic add_random(int target);
    int made, len, sel;
    action_t kind;
    logic keep;
    made = 0;
    while (made < target) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        len = $urandom_range(1, 16);
        kind = $urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT;
        keep = ($urandom_range(99) < 70);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) kind = $urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT;
          cipher_requests.push_back(cipher_request(kind, 8'($urandom_range(255)), i == 0,
                                                   i == len - 1,
                                                   (i == len - 1) ? keep : 1'($urandom)));
        end
        made += len;
      end else if (sel < 93) begin
        kind = $urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT;
        cipher_requests.push_back(cipher_request(kind, 8'($urandom), 1'($urandom),
                                                 1'($urandom), 1'($urandom)));
        made++;
      end else if (sel < 98) begin
        cipher_requests.push_back(cipher_request(ACT_UNUSED, 8'($urandom), 1'($urandom),
                                                 1'($urandom), 1'($urandom)));
        made++;
      end else begin
        cipher_requests.push_back(cipher_request(ACT_INIT, 8'($urandom), 1'($urandom),
                                                 1'($urandom), 1'($urandom)));
        made++;
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      repeat (8) @(posedge clk);
      case (ph)
        0: c = cfg_t'({$urandom, $urandom});
        1: c = '0;
        2: c = '1;
        default: c = cfg_t'({$urandom, $urandom});
      endcase
      set_config(c);
      send_idle = (ph == 0) ? 20 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 20 : 0;
      // tables must be built before any byte is ciphered
      cipher_requests.push_back(cipher_request(ACT_INIT, 8'hff, 1'b1, 1'b1, 1'b1));
      if (ph == 0) add_directed();
      add_random(RANDOM_PER_PHASE);
    end
    wait_drained();
    repeat (40) @(posedge clk);
    if (errs == 0) $display("[table_keystream_byte_cipher] OK");
    else $display("[table_keystream_byte_cipher] ERROR");
    $finish;
  end

endmodule
